// ===== hdl/fcca_pkg.sv =====
// ----------------------------------------------------------------------------
// fcca_pkg: shared definitions for the cluster chain allocator
// Widths, table markers, request and status codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fcca_pkg;

	localparam int LINK_W      = 28;
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 12;

	localparam logic [LINK_W-1:0] END_OF_CHAIN = 28'hFFFFFFF;
	localparam logic [LINK_W-1:0] END_MIN      = 28'hFFFFFF8;
	localparam logic [LINK_W-1:0] BAD_CLUSTER  = 28'hFFFFFF7;
	localparam logic [LINK_W-1:0] FIRST_DATA   = 28'd2;
	localparam logic [CNT_W-1:0]  COUNT_RESET  = 12'd4094;

	// Request kinds.
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_ALLOC = 2'd2;
	localparam logic [1:0] MODE_FREE  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_LOOP     = 2'd3;

	// Table write data selection.
	localparam logic [1:0] WR_ZERO = 2'd0;
	localparam logic [1:0] WR_VAL  = 2'd1;
	localparam logic [1:0] WR_EOC  = 2'd2;

	// Result value selection.
	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_RD   = 2'd1;
	localparam logic [1:0] RES_BAD  = 2'd2;
	localparam logic [1:0] RES_CUR  = 2'd3;

	typedef struct packed {
		logic       load;
		logic       clr_step;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       cur_inc;
		logic       cur_link;
		logic       set_res;
		logic [1:0] res_sel;
		logic [1:0] res_st;
		logic       push_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       in_table;
		logic       below_limit;
		logic       chain_live;
		logic       steps_done;
		logic       rd_zero;
		logic       clr_last;
		logic       out_free;
	} sts_t;

endpackage

// ===== hdl/fcca_if.sv =====
// ----------------------------------------------------------------------------
// fcca_if: request and response channels of the cluster chain allocator
// Valid/ready channels; a request moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface fcca_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 mode;
	logic [fcca_pkg::LINK_W-1:0] cluster_index;
	logic [fcca_pkg::LINK_W-1:0] entry_value;

	modport source (output valid, mode, cluster_index, entry_value, input ready);
	modport sink (input valid, mode, cluster_index, entry_value, output ready);
endinterface

interface fcca_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [fcca_pkg::LINK_W-1:0] result_value;
	logic [1:0]                 status;

	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface

// ===== hdl/fcca_datapath.sv =====
// ----------------------------------------------------------------------------
// fcca_datapath: table memory, walk pointer and result registers
// Holds the allocation table, the request registers, the cluster pointer and
// step counter of a scan or walk, and the response output register.
// ----------------------------------------------------------------------------
module fcca_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fcca_pkg::cmd_t                cmd,
	output fcca_pkg::sts_t                sts,
	input  logic [1:0]                    mode,
	input  logic [fcca_pkg::LINK_W-1:0]   cluster_index,
	input  logic [fcca_pkg::LINK_W-1:0]   entry_value,
	input  logic                          cfg_we,
	input  logic [fcca_pkg::CNT_W-1:0]    cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fcca_pkg::LINK_W-1:0]   out_value,
	output logic [1:0]                    out_status
);

	logic [fcca_pkg::LINK_W-1:0] mem [fcca_pkg::TABLE_DEPTH];
	logic [fcca_pkg::LINK_W-1:0] rd_data_q;
	logic [fcca_pkg::LINK_W-1:0] val_q;
	logic [fcca_pkg::LINK_W-1:0] cur_q;
	logic [fcca_pkg::LINK_W-1:0] res_q;
	logic [fcca_pkg::LINK_W-1:0] out_value_q;
	logic [fcca_pkg::LINK_W-1:0] wr_data;
	logic [fcca_pkg::LINK_W-1:0] limit;
	logic [fcca_pkg::CNT_W-1:0]  count_q;
	logic [fcca_pkg::CNT_W-1:0]  steps_q;
	logic [fcca_pkg::IDX_W-1:0]  clr_q;
	logic [fcca_pkg::IDX_W-1:0]  wr_addr;
	logic [1:0]                  mode_q;
	logic [1:0]                  st_q;
	logic [1:0]                  out_status_q;
	logic                        out_valid_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= fcca_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		case (cmd.wr_sel)
			fcca_pkg::WR_VAL: wr_data = val_q;
			fcca_pkg::WR_EOC: wr_data = fcca_pkg::END_OF_CHAIN;
			default:          wr_data = '0;
		endcase
	end

	assign wr_addr = cmd.clr_step ? clr_q : cur_q[fcca_pkg::IDX_W-1:0];

	// Table memory: one write port, one registered read port at the pointer.
	always_ff @(posedge clk) begin
		if (cmd.wr_en || cmd.clr_step) begin
			mem[wr_addr] <= cmd.clr_step ? '0 : wr_data;
		end
		rd_data_q <= mem[cur_q[fcca_pkg::IDX_W-1:0]];
	end

	// Request registers, pointer and step count.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			val_q   <= entry_value;
			cur_q   <= (mode == fcca_pkg::MODE_ALLOC) ? fcca_pkg::FIRST_DATA : cluster_index;
			steps_q <= '0;
		end else if (cmd.cur_inc) begin
			cur_q <= cur_q + 1'b1;
		end else if (cmd.cur_link) begin
			cur_q   <= rd_data_q;
			steps_q <= steps_q + 1'b1;
		end
	end

	// Result holding register.
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			st_q <= cmd.res_st;
			case (cmd.res_sel)
				fcca_pkg::RES_RD:  res_q <= rd_data_q;
				fcca_pkg::RES_BAD: res_q <= fcca_pkg::BAD_CLUSTER;
				fcca_pkg::RES_CUR: res_q <= cur_q;
				default:           res_q <= '0;
			endcase
		end
	end

	// Response output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_out) begin
			out_value_q  <= res_q;
			out_status_q <= st_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

	// Allocation bound is cluster_count + 2, computed at the full link width.
	assign limit = fcca_pkg::LINK_W'(count_q) + fcca_pkg::FIRST_DATA;

	always_comb begin
		sts.mode        = mode_q;
		sts.in_table    = (cur_q[fcca_pkg::LINK_W-1:fcca_pkg::IDX_W] == '0);
		sts.below_limit = (cur_q < limit);
		sts.chain_live  = (cur_q >= fcca_pkg::FIRST_DATA) && (cur_q < fcca_pkg::END_MIN);
		sts.steps_done  = (steps_q >= count_q);
		sts.rd_zero     = (rd_data_q == '0);
		sts.clr_last    = (clr_q == '1);
		sts.out_free    = !out_valid_q || out_ready;
	end

endmodule

// ===== hdl/fcca_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcca_ctrl: request sequencer of the cluster chain allocator
// Runs the clearing pass after reset, then steps each request through
// check and, where needed, evaluate cycles and hands the result to the output register.
// ----------------------------------------------------------------------------
module fcca_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fcca_pkg::sts_t sts,
	output fcca_pkg::cmd_t cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			// The pointer is settled here; the table read issued now is seen in EVAL.
			S_CHECK: begin
				state_d = S_EVAL;
				case (sts.mode)
					fcca_pkg::MODE_READ: begin
						if (!sts.in_table) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = fcca_pkg::RES_BAD;
							cmd.res_st  = fcca_pkg::ST_RANGE;
							state_d     = S_DONE;
						end
					end
					fcca_pkg::MODE_SET: begin
						cmd.set_res = 1'b1;
						cmd.res_sel = fcca_pkg::RES_ZERO;
						state_d     = S_DONE;
						if (sts.in_table) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = fcca_pkg::WR_VAL;
							cmd.res_st = fcca_pkg::ST_OK;
						end else begin
							cmd.res_st = fcca_pkg::ST_RANGE;
						end
					end
					fcca_pkg::MODE_ALLOC: begin
						if (!sts.below_limit || !sts.in_table) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = fcca_pkg::RES_ZERO;
							cmd.res_st  = fcca_pkg::ST_NO_SPACE;
							state_d     = S_DONE;
						end
					end
					default: begin
						cmd.res_sel = fcca_pkg::RES_ZERO;
						if (!sts.chain_live) begin
							cmd.set_res = 1'b1;
							cmd.res_st  = fcca_pkg::ST_OK;
							state_d     = S_DONE;
						end else if (!sts.in_table) begin
							cmd.set_res = 1'b1;
							cmd.res_st  = fcca_pkg::ST_RANGE;
							state_d     = S_DONE;
						end else if (sts.steps_done) begin
							cmd.set_res = 1'b1;
							cmd.res_st  = fcca_pkg::ST_LOOP;
							state_d     = S_DONE;
						end
					end
				endcase
			end
			S_EVAL: begin
				case (sts.mode)
					fcca_pkg::MODE_READ: begin
						cmd.set_res = 1'b1;
						cmd.res_sel = fcca_pkg::RES_RD;
						cmd.res_st  = fcca_pkg::ST_OK;
						state_d     = S_DONE;
					end
					fcca_pkg::MODE_ALLOC: begin
						if (sts.rd_zero) begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = fcca_pkg::WR_EOC;
							cmd.set_res = 1'b1;
							cmd.res_sel = fcca_pkg::RES_CUR;
							cmd.res_st  = fcca_pkg::ST_OK;
							state_d     = S_DONE;
						end else begin
							cmd.cur_inc = 1'b1;
							state_d     = S_CHECK;
						end
					end
					default: begin
						// Free chain: clear this entry and follow its old link.
						cmd.wr_en    = 1'b1;
						cmd.wr_sel   = fcca_pkg::WR_ZERO;
						cmd.cur_link = 1'b1;
						state_d      = S_CHECK;
					end
				endcase
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.push_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/fat_cluster_chain_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_unit: FAT32-style cluster chain allocator
// Holds a 4096-entry allocation table and serves read, set, allocate and
// free-chain requests, one response per request.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel (mode, cluster_index, entry_value) and
// each produces exactly one response on the rsp channel (result_value,
// status). Both channels are valid/ready; a request is taken when valid and
// ready are high at a clock edge. cfg_we with cfg_wdata loads cluster_count;
// write it only while no request is in flight.
// After arst_n is released the block runs a clearing pass that writes zero
// to all 4096 table entries, one per cycle; req.ready stays low until the pass
// is done.
// The table has one read port, so a walk visits one entry at a time: the
// pointer is set, then its registered read data is evaluated.
// One request is worked on at a time. The finished response sits in an
// output register, so the next request is accepted while it waits; if rsp
// stalls, a second finished response holds the sequencer until it drains.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	fcca_req_if.sink                    req,
	fcca_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [fcca_pkg::CNT_W-1:0]  cfg_wdata
);

	fcca_pkg::cmd_t cmd;
	fcca_pkg::sts_t sts;
	logic           in_ready;

	// Sequencer: clearing pass, per-request check/evaluate steps.
	fcca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	// Table memory, walk pointer and response register.
	fcca_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (req.mode),
		.cluster_index (req.cluster_index),
		.entry_value   (req.entry_value),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_value     (rsp.result_value),
		.out_status    (rsp.status)
	);

endmodule
